// ===== sv/pzse_pkg.sv =====
`timescale 1ns / 1ps
package pzse_pkg;

    localparam int FRAME_WIDTH_DEF  = 200;
    localparam int FRAME_HEIGHT_DEF = 100;
    localparam int CUBE_STEPS_DEF   = 10;

    localparam int GRID_W     = 4;
    localparam int CELL_W     = 15;
    localparam int CHAR_W     = 8;
    localparam int TRIG_W     = 16;
    localparam int VD_W       = 8;
    localparam int OFF_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEPTH_W = 16;
    localparam int SHADE_W = 4;
    localparam int ENTRY_W = DEPTH_W + SHADE_W;

    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 40;

    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY  = 16'hFFFF;
    localparam logic [SHADE_W-1:0] BLANK_CODE   = 4'd12;
    localparam logic [SHADE_W-1:0] SHADE_MAX    = 4'd11;
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_A,
        REG_SIN_A,
        REG_COS_B,
        REG_SIN_B,
        REG_VIEW_DISTANCE,
        REG_DEPTH_OFFSET
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RCHK,
        ST_RMUL,
        ST_RWAIT,
        ST_Y1A,
        ST_Y1B,
        ST_Z1A,
        ST_Z1B,
        ST_RXA,
        ST_RXB,
        ST_RZA,
        ST_RZB,
        ST_NXM,
        ST_NYM,
        ST_ZTEST,
        ST_DIVX,
        ST_DIVY,
        ST_SYM,
        ST_POS,
        ST_PCHK,
        ST_SHADE,
        ST_PWR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] ramp_char(input logic [SHADE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            4'd0:    ch = 8'h2E;
            4'd1:    ch = 8'h2C;
            4'd2:    ch = 8'h2D;
            4'd3:    ch = 8'h7E;
            4'd4:    ch = 8'h3A;
            4'd5:    ch = 8'h3B;
            4'd6:    ch = 8'h3D;
            4'd7:    ch = 8'h21;
            4'd8:    ch = 8'h2A;
            4'd9:    ch = 8'h23;
            4'd10:   ch = 8'h24;
            4'd11:   ch = 8'h40;
            default: ch = CHAR_SPACE;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/pzse_if.sv =====
`timescale 1ns / 1ps
interface pzse_item_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [pzse_pkg::GRID_W-1:0]  grid_x;
    logic [pzse_pkg::GRID_W-1:0]  grid_y;
    logic [pzse_pkg::GRID_W-1:0]  grid_z;
    logic [pzse_pkg::CELL_W-1:0]  cell_req;

    modport source (output valid, mode, grid_x, grid_y, grid_z, cell_req, input ready);
    modport sink   (input valid, mode, grid_x, grid_y, grid_z, cell_req, output ready);
endinterface

interface pzse_result_if;
    logic                         valid;
    logic                         ready;
    logic [pzse_pkg::CHAR_W-1:0]  char_code;
    logic                         plotted;
    logic [pzse_pkg::CELL_W-1:0]  cell_index;

    modport source (output valid, char_code, plotted, cell_index, input ready);
    modport sink   (input valid, char_code, plotted, cell_index, output ready);
endinterface

// ===== sv/pzse_ram.sv =====
`timescale 1ns / 1ps
module pzse_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 20000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/pzse_div.sv =====
`timescale 1ns / 1ps
module pzse_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pzse_pkg::DIV_N_W-1:0]  dividend,
    input  logic [pzse_pkg::DIV_D_W-1:0]  divisor,
    output pzse_pkg::div_stat_t           stat,
    output logic [pzse_pkg::DIV_N_W-1:0]  quot
);
    import pzse_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] quot_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W+1:0] trial;
    logic               fits;

    assign shifted = {rem_reg, quot_reg[DIV_N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[DIV_D_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when the divisor fits
            rem_reg  <= fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quot_reg <= {quot_reg[DIV_N_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
endmodule

// ===== sv/point_zbuffer_shade_engine_core.sv =====
// Plots cube lattice points into a depth-tested frame of shade codes, or reads
// one frame cell back as an ASCII character and clears it; every transaction
// yields exactly one result. After reset the block sweeps the frame store, one
// cell per cycle, before it takes its first transaction; configuration writes
// are taken throughout. A plot runs eleven products through one shared
// multiplier and the shared 48-step divider once per screen coordinate, and
// ends early when the point lies behind the viewer or outside the frame; the
// shade index comes from compares against multiples of CUBE_STEPS, and a read
// finds its row by a multiply with the reciprocal of FRAME_WIDTH, and from it
// whether the cell lies in column zero. One item is in work at a time.
`timescale 1ns / 1ps
module point_zbuffer_shade_engine_core #(
    parameter int FRAME_WIDTH  = pzse_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = pzse_pkg::FRAME_HEIGHT_DEF,
    parameter int CUBE_STEPS   = pzse_pkg::CUBE_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [pzse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pzse_pkg::CFG_DATA_W-1:0]  cfg_data,
    pzse_item_if.sink                        item,
    pzse_result_if.source                    result
);
    import pzse_pkg::*;

    localparam int CELL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CENTER     = FRAME_WIDTH / 2 + (FRAME_HEIGHT / 2) * FRAME_WIDTH;
    // row = (cell * REC_MULT) >> REC_SHIFT, exact for every cell of the frame
    localparam int     REC_SHIFT = ADDR_W + $clog2(FRAME_WIDTH);
    localparam longint REC_MULT  = ((64'sd1 <<< REC_SHIFT) + FRAME_WIDTH - 1) / FRAME_WIDTH;

    state_t state_reg, state_next;

    // configuration
    logic signed [TRIG_W-1:0] cos_a_reg, sin_a_reg, cos_b_reg, sin_b_reg;
    logic [VD_W-1:0]          vd_reg;
    logic [OFF_W-1:0]         off_reg;

    // datapath
    logic signed [7:0]   px_reg, py_reg, pz_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic signed [23:0]  y1_reg, z1_reg;
    logic signed [39:0]  rx_reg, rz_reg;
    logic signed [40:0]  z_reg;
    logic signed [40:0]  lnum_reg;
    logic signed [47:0]  nx_reg, ny_reg;
    logic signed [48:0]  sx_reg, sy_reg;
    logic signed [59:0]  pos_reg;
    logic [SHADE_W-1:0]  shade_reg;
    logic signed [65:0]  prod_reg;
    logic [ADDR_W-1:0]   clr_reg;

    logic [CHAR_W-1:0]   res_char_reg;
    logic                res_plot_reg;
    logic [CELL_W-1:0]   res_cell_reg;
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_plot_reg;
    logic [CELL_W-1:0]   out_cell_reg;

    // shared units
    logic signed [48:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic                div_start;
    logic [DIV_N_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0]  div_divisor;
    div_stat_t           div_stat;
    logic [DIV_N_W-1:0]  div_quot;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic signed [21:0]  x1;
    logic signed [40:0]  ry;
    logic [DEPTH_W-1:0]  dcode;
    logic [44:0]         l12;
    logic [15:0]         light;
    logic                lit;
    logic                pos_out;
    logic [DIV_N_W-1:0]  nx_mag, ny_mag;
    logic signed [48:0]  q_signed;
    logic                out_free;
    logic                cell_in;
    logic                col_zero;

    function automatic logic [SHADE_W-1:0] shade_index(input logic [15:0] lv);
        logic [SHADE_W-1:0] cnt;
        cnt = '0;
        // count the multiples of CUBE_STEPS reached, up to the top of the ramp
        for (int k = 1; k <= int'(SHADE_MAX); k++)
        begin
            if (32'(lv) >= 32'(k * CUBE_STEPS))
            begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

    assign x1       = {px_reg, 14'b0};
    assign ry       = 41'(y1_reg) <<< 14;
    assign dcode    = (z_reg[40:37] != '0) ? DEPTH_EMPTY : z_reg[36:21];
    assign l12      = (45'(lnum_reg) << 3) + (45'(lnum_reg) << 2);
    assign light    = l12[44:29];
    assign lit      = (lnum_reg > 0);
    assign pos_out  = (pos_reg < 0) || (pos_reg >= 60'(CELL_COUNT));
    assign nx_mag   = nx_reg[47] ? 48'(-nx_reg) : 48'(nx_reg);
    assign ny_mag   = ny_reg[47] ? 48'(-ny_reg) : 48'(ny_reg);
    assign q_signed = $signed({1'b0, div_quot});
    assign out_free = !out_valid_reg || result.ready;
    assign cell_in  = (32'(cell_reg) < 32'(CELL_COUNT));
    assign col_zero = (prod_reg == $signed(66'(cell_reg)));

    pzse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    pzse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == ADDR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = item.mode ? ST_RCHK : ST_Y1A;
                end
            end
            ST_RCHK:  state_next = cell_in ? ST_RMUL : ST_DONE;
            ST_RMUL:  state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_DONE;
            ST_Y1A:   state_next = ST_Y1B;
            ST_Y1B:   state_next = ST_Z1A;
            ST_Z1A:   state_next = ST_Z1B;
            ST_Z1B:   state_next = ST_RXA;
            ST_RXA:   state_next = ST_RXB;
            ST_RXB:   state_next = ST_RZA;
            ST_RZA:   state_next = ST_RZB;
            ST_RZB:   state_next = ST_NXM;
            ST_NXM:   state_next = ST_NYM;
            ST_NYM:   state_next = ST_ZTEST;
            ST_ZTEST: state_next = (z_reg <= 0) ? ST_DONE : ST_DIVX;
            ST_DIVX:  if (div_stat.done) state_next = ST_DIVY;
            ST_DIVY:  if (div_stat.done) state_next = ST_SYM;
            ST_SYM:   state_next = ST_POS;
            ST_POS:   state_next = ST_PCHK;
            ST_PCHK:  state_next = pos_out ? ST_DONE : ST_SHADE;
            ST_SHADE: state_next = ST_PWR;
            ST_PWR:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = nx_mag;
        div_divisor  = 40'(z_reg);
        ram_we       = 1'b0;
        ram_addr     = pos_reg[ADDR_W-1:0];
        ram_wdata    = {DEPTH_EMPTY, BLANK_CODE};
        item.ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            ST_RCHK:
            begin
                ram_addr = ADDR_W'(cell_reg);
                mul_a    = 49'(REC_MULT);
                mul_b    = $signed(17'(cell_reg));
            end
            ST_RMUL:
            begin
                ram_addr = ADDR_W'(cell_reg);
                mul_a    = 49'(prod_reg >>> REC_SHIFT);
                mul_b    = 17'(FRAME_WIDTH);
            end
            ST_RWAIT:
            begin
                ram_addr = ADDR_W'(cell_reg);
                ram_we   = 1'b1;
            end
            ST_Y1A:  begin mul_a = 49'(py_reg); mul_b = 17'(cos_a_reg); end
            ST_Y1B:  begin mul_a = 49'(pz_reg); mul_b = 17'(sin_a_reg); end
            ST_Z1A:  begin mul_a = 49'(pz_reg); mul_b = 17'(cos_a_reg); end
            ST_Z1B:  begin mul_a = 49'(py_reg); mul_b = 17'(sin_a_reg); end
            ST_RXA:  begin mul_a = 49'(x1);     mul_b = 17'(cos_b_reg); end
            ST_RXB:  begin mul_a = 49'(z1_reg); mul_b = 17'(sin_b_reg); end
            ST_RZA:  begin mul_a = 49'(x1);     mul_b = 17'(sin_b_reg); end
            ST_RZB:  begin mul_a = 49'(z1_reg); mul_b = 17'(cos_b_reg); end
            ST_NXM:  begin mul_a = 49'(rx_reg); mul_b = $signed(17'(vd_reg)); end
            ST_NYM:  begin mul_a = 49'(ry);     mul_b = $signed(17'(vd_reg)); end
            ST_ZTEST: div_start = (z_reg > 0);
            ST_DIVX:
            begin
                div_start    = div_stat.done;
                div_dividend = ny_mag;
            end
            ST_SYM:  begin mul_a = sy_reg; mul_b = 17'(FRAME_WIDTH); end
            ST_PWR:
            begin
                ram_we    = (dcode < ram_rdata[ENTRY_W-1:SHADE_W]);
                ram_wdata = {dcode, shade_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cos_a_reg     <= 16'sd16384;
            sin_a_reg     <= '0;
            cos_b_reg     <= 16'sd16384;
            sin_b_reg     <= '0;
            vd_reg        <= 8'd70;
            off_reg       <= 7'd20;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COS_A:         cos_a_reg <= cfg_data;
                    REG_SIN_A:         sin_a_reg <= cfg_data;
                    REG_COS_B:         cos_b_reg <= cfg_data;
                    REG_SIN_B:         sin_b_reg <= cfg_data;
                    REG_VIEW_DISTANCE: vd_reg    <= cfg_data[VD_W-1:0];
                    REG_DEPTH_OFFSET:  off_reg   <= cfg_data[OFF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                px_reg   <= $signed({3'b000, item.grid_x, 1'b0}) - 8'(CUBE_STEPS);
                py_reg   <= $signed({3'b000, item.grid_y, 1'b0}) - 8'(CUBE_STEPS);
                pz_reg   <= $signed({3'b000, item.grid_z, 1'b0}) - 8'(CUBE_STEPS);
                cell_reg <= item.cell_req;
            end
            ST_RCHK:
            begin
                res_char_reg <= CHAR_SPACE;
                res_plot_reg <= 1'b0;
                res_cell_reg <= cell_reg;
            end
            ST_RWAIT:
            begin
                if (col_zero)
                begin
                    res_char_reg <= CHAR_NEWLINE;
                end
                else
                begin
                    res_char_reg <= ramp_char(ram_rdata[SHADE_W-1:0]);
                end
            end
            ST_Y1B:  y1_reg <= 24'(prod_reg);
            ST_Z1A:  y1_reg <= y1_reg + 24'(prod_reg);
            ST_Z1B:  z1_reg <= 24'(prod_reg);
            ST_RXA:  z1_reg <= z1_reg - 24'(prod_reg);
            ST_RXB:  rx_reg <= 40'(prod_reg);
            ST_RZA:  rx_reg <= rx_reg - 40'(prod_reg);
            ST_RZB:  rz_reg <= 40'(prod_reg);
            ST_NXM:  rz_reg <= rz_reg + 40'(prod_reg);
            ST_NYM:
            begin
                z_reg  <= 41'(rz_reg) + 41'({off_reg, 29'b0});
                nx_reg <= 48'(prod_reg);
            end
            ST_ZTEST:
            begin
                ny_reg       <= 48'(prod_reg);
                lnum_reg     <= -(ry + 41'(rz_reg));
                res_char_reg <= '0;
                res_plot_reg <= 1'b0;
                res_cell_reg <= '0;
            end
            ST_DIVX: if (div_stat.done) sx_reg <= nx_reg[47] ? -q_signed : q_signed;
            ST_DIVY: if (div_stat.done) sy_reg <= ny_reg[47] ? -q_signed : q_signed;
            ST_POS:  pos_reg <= 60'(prod_reg) + 60'(sx_reg) + 60'(CENTER);
            ST_PCHK: if (!pos_out) res_cell_reg <= pos_reg[CELL_W-1:0];
            ST_SHADE:
            begin
                if (!lit)
                begin
                    shade_reg <= '0;
                end
                else
                begin
                    shade_reg <= shade_index(light);
                end
            end
            ST_PWR:  res_plot_reg <= (dcode < ram_rdata[ENTRY_W-1:SHADE_W]);
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_char_reg <= res_char_reg;
                    out_plot_reg <= res_plot_reg;
                    out_cell_reg <= res_cell_reg;
                end
            end
            default: ;
        endcase
    end

    assign result.valid      = out_valid_reg;
    assign result.char_code  = out_char_reg;
    assign result.plotted    = out_plot_reg;
    assign result.cell_index = out_cell_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !item.ready)
        else $error("transaction accepted during store sweep");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_plot_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.plotted) |-> (result.char_code == '0))
        else $error("plot result carries a character");
endmodule
